// ===== src/lpgt_pkg.sv =====
// Shared types and constants for the linear probe group table.
package lpgt_pkg;

  localparam int HASH_W      = 64;
  localparam int KEY_FIELD_W = 64;
  localparam int CMD_W       = 1;
  localparam int ENTRY_W     = 10;
  localparam int ENTRY_DEPTH = 1 << ENTRY_W;
  localparam int COUNT_W     = 11;
  localparam int LG_W        = 4;
  localparam int MAXE_W      = 10;

  localparam int MAX_BUCKETS_DEF = 1024;
  localparam int KEY_WIDTH_DEF   = 64;

  localparam logic [LG_W-1:0]   LG_MIN         = 4'd1;
  localparam logic [LG_W-1:0]   LG_MAX         = 4'd10;
  localparam logic [LG_W-1:0]   LG_RESET       = 4'd10;
  localparam logic [MAXE_W-1:0] MAXE_RESET     = 10'd768;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE_LOG2 = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_ENTRIES     = 1'b1;

  localparam logic [CMD_W-1:0] CMD_FIND_OR_CREATE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FIND_ONLY      = 1'b1;

  typedef enum logic [1:0] {
    ST_MATCHED   = 2'd0,
    ST_CREATED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

endpackage

// ===== src/lpgt_if.sv =====
// Query and answer channel interfaces of the linear probe group table.
interface lpgt_query_if;
  import lpgt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [HASH_W-1:0]      hash_value;
  logic [KEY_FIELD_W-1:0] key_value;
  modport source (output valid, command, hash_value, key_value, input ready);
  modport sink   (input valid, command, hash_value, key_value, output ready);
endinterface

interface lpgt_answer_if;
  import lpgt_pkg::*;
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ENTRY_W-1:0] group_index;
  modport source (output valid, status, group_index, input ready);
  modport sink   (input valid, status, group_index, output ready);
endinterface

// ===== src/lpgt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module lpgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/linear_probe_group_table.sv =====
// Group-by hash table with open addressing and linear probing.
//
// Query channel: command, hash_value, key_value. Answer channel: status,
// group_index, one answer per query, in order. Registers table_size_log2
// (0x0) and max_entries (0x4) are written over the APB port; the user must
// write them only while idle, which the block does not enforce.
// The bucket store is one RAM read per cycle, so a query is taken in, then
// probes one bucket at a time in S_BUCKET, and for each probed bucket whose
// stored hash equals the query hash also passes through S_KEY (key store
// read). An empty bucket at the start position is answered from S_BUCKET,
// a hit there from S_KEY; the next query is taken once the answer is
// registered.
//
// After reset the block clears the bucket store, one bucket per cycle, over
// all MAX_BUCKETS buckets, query ready low; configuration writes are taken.
// The answer sits in an output register; while the receiver stalls, a
// finished query waits in a result register and no new query is taken.
module linear_probe_group_table #(
  parameter int MAX_BUCKETS = lpgt_pkg::MAX_BUCKETS_DEF,
  parameter int KEY_WIDTH   = lpgt_pkg::KEY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  lpgt_query_if.sink                      query,
  lpgt_answer_if.source                   answer,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpgt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lpgt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lpgt_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import lpgt_pkg::*;

  localparam int BW         = $clog2(MAX_BUCKETS);
  localparam int BKT_LG_MAX = $clog2(MAX_BUCKETS + 1) - 1;
  localparam int BKT_W      = 1 + HASH_W + ENTRY_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BUCKET,
    S_KEY,
    S_EMIT
  } state_t;

  state_t               state;
  logic [BW-1:0]        clr_addr;
  logic [BW-1:0]        cur_bucket;
  logic [BW:0]          visited;
  logic                 q_create;
  logic [HASH_W-1:0]    q_hash;
  logic [KEY_WIDTH-1:0] q_key;
  logic [ENTRY_W-1:0]   hit_entry;
  logic [COUNT_W-1:0]   entry_count;
  logic [LG_W-1:0]      table_size_log2;
  logic [MAXE_W-1:0]    max_entries;
  logic                 out_valid;
  status_t              out_status;
  logic [ENTRY_W-1:0]   out_group;
  status_t              res_status;
  logic [ENTRY_W-1:0]   res_group;

  logic [LG_W-1:0]      lg_cl;
  logic [LG_W-1:0]      lg_eff;
  logic [BW:0]          n_bkt;
  logic [BW-1:0]        mask;
  logic [BW-1:0]        start_bkt;
  logic [BW-1:0]        next_bkt;
  logic                 last_visit;
  logic                 can_insert;
  logic [ENTRY_W-1:0]   new_entry;
  status_t              fail_status;

  logic                 bkt_we;
  logic [BW-1:0]        bkt_waddr;
  logic [BKT_W-1:0]     bkt_wdata;
  logic [BW-1:0]        bkt_raddr;
  logic [BKT_W-1:0]     bkt_rdata;
  logic                 rd_valid;
  logic [HASH_W-1:0]    rd_hash;
  logic [ENTRY_W-1:0]   rd_entry;

  logic                 key_we;
  logic [KEY_WIDTH-1:0] key_rdata;

  logic                 insert;
  logic                 go_key;
  logic                 advance;
  logic                 done;
  status_t              fin_status;
  logic [ENTRY_W-1:0]   fin_group;
  logic                 slot_free;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  assign rd_valid  = bkt_rdata[BKT_W-1];
  assign rd_hash   = bkt_rdata[ENTRY_W +: HASH_W];
  assign rd_entry  = bkt_rdata[ENTRY_W-1:0];
  assign new_entry = entry_count[ENTRY_W-1:0];
  assign slot_free = !out_valid || answer.ready;
  assign reg_idx   = paddr[APB_ADDR_W-1:2];
  assign cfg_wr    = psel && penable && pwrite;

  always_comb begin
    if (table_size_log2 < LG_MIN) begin
      lg_cl = LG_MIN;
    end else if (table_size_log2 > LG_MAX) begin
      lg_cl = LG_MAX;
    end else begin
      lg_cl = table_size_log2;
    end
    if (int'(lg_cl) > BKT_LG_MAX) begin
      lg_eff = LG_W'(BKT_LG_MAX);
    end else begin
      lg_eff = lg_cl;
    end
    n_bkt       = (BW + 1)'(1) << lg_eff;
    mask        = BW'(n_bkt - (BW + 1)'(1));
    start_bkt   = query.hash_value[BW-1:0] & mask;
    next_bkt    = (cur_bucket + BW'(1)) & mask;
    last_visit  = (visited + (BW + 1)'(1)) == n_bkt;
    can_insert  = q_create && (entry_count < COUNT_W'(max_entries));
    fail_status = q_create ? ST_FULL : ST_NOT_FOUND;
  end

  always_comb begin
    insert     = 1'b0;
    go_key     = 1'b0;
    advance    = 1'b0;
    done       = 1'b0;
    fin_status = res_status;
    fin_group  = res_group;
    case (state)
      S_BUCKET: begin
        if (!rd_valid) begin
          done       = 1'b1;
          insert     = can_insert;
          fin_status = can_insert ? ST_CREATED : fail_status;
          fin_group  = can_insert ? new_entry : '0;
        end else if (rd_hash == q_hash) begin
          go_key = 1'b1;
        end else if (last_visit) begin
          done       = 1'b1;
          fin_status = fail_status;
          fin_group  = '0;
        end else begin
          advance = 1'b1;
        end
      end
      S_KEY: begin
        if (key_rdata == q_key) begin
          done       = 1'b1;
          fin_status = ST_MATCHED;
          fin_group  = hit_entry;
        end else if (last_visit) begin
          done       = 1'b1;
          fin_status = fail_status;
          fin_group  = '0;
        end else begin
          advance = 1'b1;
        end
      end
      S_EMIT: begin
        done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    bkt_raddr = (state == S_IDLE) ? start_bkt : next_bkt;
    if (state == S_CLEAR) begin
      bkt_we    = 1'b1;
      bkt_waddr = clr_addr;
      bkt_wdata = '0;
    end else begin
      bkt_we    = insert;
      bkt_waddr = cur_bucket;
      bkt_wdata = {1'b1, q_hash, new_entry};
    end
    key_we = insert;
  end

  lpgt_ram #(
    .WIDTH (BKT_W),
    .DEPTH (MAX_BUCKETS)
  ) u_bucket_ram (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (bkt_wdata),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  lpgt_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (ENTRY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (new_entry),
    .wdata (q_key),
    .raddr (rd_entry),
    .rdata (key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      out_valid       <= 1'b0;
      entry_count     <= '0;
      table_size_log2 <= LG_RESET;
      max_entries     <= MAXE_RESET;
    end else begin
      if (cfg_wr) begin
        case (reg_idx)
          REG_TABLE_SIZE_LOG2: table_size_log2 <= pwdata[LG_W-1:0];
          REG_MAX_ENTRIES:     max_entries     <= pwdata[MAXE_W-1:0];
          default: begin
          end
        endcase
      end
      if (done && slot_free) begin
        out_valid <= 1'b1;
      end else if (answer.ready) begin
        out_valid <= 1'b0;
      end
      if (insert) begin
        entry_count <= entry_count + COUNT_W'(1);
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + BW'(1);
          if (clr_addr == BW'(MAX_BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (query.valid) begin
            q_create   <= (query.command == CMD_FIND_OR_CREATE);
            q_hash     <= query.hash_value;
            q_key      <= query.key_value[KEY_WIDTH-1:0];
            cur_bucket <= start_bkt;
            visited    <= '0;
            state      <= S_BUCKET;
          end
        end
        S_BUCKET, S_KEY, S_EMIT: begin
          if (done) begin
            if (slot_free) begin
              out_status <= fin_status;
              out_group  <= fin_group;
              state      <= S_IDLE;
            end else begin
              res_status <= fin_status;
              res_group  <= fin_group;
              state      <= S_EMIT;
            end
          end else if (go_key) begin
            hit_entry <= rd_entry;
            state     <= S_KEY;
          end else if (advance) begin
            cur_bucket <= next_bkt;
            visited    <= visited + (BW + 1)'(1);
            state      <= S_BUCKET;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TABLE_SIZE_LOG2: prdata = APB_DATA_W'(table_size_log2);
      REG_MAX_ENTRIES:     prdata = APB_DATA_W'(max_entries);
      default:             prdata = '0;
    endcase
  end

  assign pready             = 1'b1;
  assign query.ready        = (state == S_IDLE);
  assign answer.valid       = out_valid;
  assign answer.status      = out_status;
  assign answer.group_index = out_group;

endmodule

// ===== src/lpgt_checker.sv =====
// Port-level checks for the linear probe group table, bound to the top level.
module lpgt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          q_valid,
  input logic                          q_ready,
  input logic                          a_valid,
  input logic                          a_ready,
  input logic [1:0]                    a_status,
  input logic [lpgt_pkg::ENTRY_W-1:0]  a_group
);
  import lpgt_pkg::*;

  logic [1:0] pending;
  logic       q_acc;
  logic       a_acc;

  assign q_acc = q_valid && q_ready;
  assign a_acc = a_valid && a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (q_acc && !a_acc) begin
      pending <= pending + 2'd1;
    end else if (a_acc && !q_acc) begin
      pending <= pending - 2'd1;
    end
  end

  a_answer_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_ready |=> a_valid && $stable(a_status) && $stable(a_group))
    else $error("answer item changed while stalled");

  a_no_extra_answer: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> pending != 2'd0)
    else $error("answer item without a pending query");

  a_fail_group_zero: assert property (@(posedge clk) disable iff (rst)
    a_valid && (a_status == ST_NOT_FOUND || a_status == ST_FULL) |-> a_group == '0)
    else $error("group index nonzero on a miss");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> !q_ready)
    else $error("query taken during clearing pass");

endmodule

bind linear_probe_group_table lpgt_checker u_lpgt_checker (
  .clk      (clk),
  .rst      (rst),
  .q_valid  (query.valid),
  .q_ready  (query.ready),
  .a_valid  (answer.valid),
  .a_ready  (answer.ready),
  .a_status (answer.status),
  .a_group  (answer.group_index)
);

// ===== sim/tb_linear_probe_group_table.sv =====
// Self-checking testbench for the linear probe group table: random and directed queries.
module tb_linear_probe_group_table;
  timeunit 1ns;
  timeprecision 1ps;
  import lpgt_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0]       command;
    logic [HASH_W-1:0]      hash;
    logic [KEY_FIELD_W-1:0] key;
  } query_t;

  typedef struct packed {
    logic [HASH_W-1:0]      hash;
    logic [KEY_FIELD_W-1:0] key;
  } key_pair_t;

  typedef struct {
    status_t            status;
    logic [ENTRY_W-1:0] group;
  } answer_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  lpgt_query_if  query_bus ();
  lpgt_answer_if answer_bus ();

  linear_probe_group_table u_top (
    .clk     (clk),
    .rst     (rst),
    .query   (query_bus),
    .answer  (answer_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the table
  logic               bkt_used  [MAX_BUCKETS_DEF];
  logic [HASH_W-1:0]  bkt_hash  [MAX_BUCKETS_DEF];
  logic [ENTRY_W-1:0] bkt_entry [MAX_BUCKETS_DEF];
  logic [KEY_FIELD_W-1:0] entry_key [ENTRY_DEPTH];
  logic [COUNT_W-1:0] group_count;
  logic [LG_W-1:0]    cfg_lg;
  logic [MAXE_W-1:0]  cfg_max;

  query_t    pending_queries[$];
  answer_t   expected_answers[$];
  key_pair_t known_pairs[$];

  int idle_pct = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int mismatches = 0;
  int answers_seen = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  answer_t head_answer;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic answer_t lookup_group(query_t q);
    int unsigned lg, nb, b, visited;
    logic make;
    answer_t r;
    lg = cfg_lg;
    if (lg < 1) lg = 1;
    if (lg > 10) lg = 10;
    nb = 1 << lg;
    if (nb > MAX_BUCKETS_DEF) nb = MAX_BUCKETS_DEF;
    make = (q.command == CMD_FIND_OR_CREATE);
    r.status = make ? ST_FULL : ST_NOT_FOUND;
    r.group = '0;
    b = q.hash[31:0] & (nb - 1);
    for (visited = 0; visited < nb; visited++) begin
      if (!bkt_used[b]) begin
        if (make && group_count < {1'b0, cfg_max}) begin
          bkt_used[b] = 1'b1;
          bkt_hash[b] = q.hash;
          bkt_entry[b] = group_count[ENTRY_W-1:0];
          entry_key[group_count[ENTRY_W-1:0]] = q.key;
          r.status = ST_CREATED;
          r.group = group_count[ENTRY_W-1:0];
          group_count = group_count + 1'b1;
        end
        break;
      end
      if (bkt_hash[b] == q.hash && entry_key[bkt_entry[b]] == q.key) begin
        r.status = ST_MATCHED;
        r.group = bkt_entry[b];
        break;
      end
      b = (b + 1) & (nb - 1);
    end
    return r;
  endfunction

  // mostly repeats and near-misses of earlier keys, the rest fresh
  function automatic query_t random_query();
    query_t q;
    key_pair_t p;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    q.command = ($urandom_range(0, 3) == 0) ? CMD_FIND_ONLY : CMD_FIND_OR_CREATE;
    q.hash = {$urandom(), $urandom()};
    q.key = {$urandom(), $urandom()};
    if (known_pairs.size() > 0 && pick < 70) begin
      p = known_pairs[$urandom_range(0, known_pairs.size() - 1)];
      if (pick < 45) begin
        q.hash = p.hash;
        q.key = p.key;
      end else if (pick < 60) begin
        q.hash = p.hash;
      end else begin
        q.hash = p.hash ^ (q.hash << ENTRY_W);
      end
    end
    if (pick >= 45) known_pairs = {known_pairs, key_pair_t'({q.hash, q.key})};
    return q;
  endfunction

  task automatic push_query(input logic [CMD_W-1:0] cmd, input logic [HASH_W-1:0] h,
                            input logic [KEY_FIELD_W-1:0] k);
    pending_queries = {pending_queries, query_t'({cmd, h, k})};
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [APB_DATA_W-1:0] word;
    word = $urandom();
    if (idx == REG_TABLE_SIZE_LOG2) word[LG_W-1:0] = value[LG_W-1:0];
    else word[MAXE_W-1:0] = value[MAXE_W-1:0];
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TABLE_SIZE_LOG2) cfg_lg = value[LG_W-1:0];
    else cfg_max = value[MAXE_W-1:0];
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_queries.size() != 0 || expected_answers.size() != 0 || query_bus.valid);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [LG_W-1:0] lg, input logic [MAXE_W-1:0] maxe);
    wait_idle();
    reg_write(REG_TABLE_SIZE_LOG2, 32'(lg));
    reg_write(REG_MAX_ENTRIES, 32'(maxe));
  endtask

  task automatic random_phase(input logic [LG_W-1:0] lg, input logic [MAXE_W-1:0] maxe,
                              input int n, input int pct);
    set_config(lg, maxe);
    idle_pct = pct;
    repeat (n) pending_queries = {pending_queries, random_query()};
  endtask

  // query driver
  always @(posedge clk) begin : drive
    query_t nq;
    if (rst) begin
      query_bus.valid <= 1'b0;
      query_bus.command <= CMD_FIND_OR_CREATE;
      query_bus.hash_value <= '0;
      query_bus.key_value <= '0;
      send_gap = 0;
    end else begin
      if (query_bus.valid && query_bus.ready)
        expected_answers = {expected_answers,
                            lookup_group({query_bus.command, query_bus.hash_value,
                                          query_bus.key_value})};
      if (query_bus.valid && !query_bus.ready) begin
      end else if (send_gap > 0) begin
        send_gap--;
        query_bus.valid <= 1'b0;
      end else if (pending_queries.size() > 0 && idle_pct > 0 &&
                   $urandom_range(0, 99) < idle_pct) begin
        send_gap = $urandom_range(0, 8);
        query_bus.valid <= 1'b0;
      end else if (pending_queries.size() > 0) begin
        nq = pending_queries.pop_front();
        query_bus.valid <= 1'b1;
        query_bus.command <= nq.command;
        query_bus.hash_value <= nq.hash;
        query_bus.key_value <= nq.key;
      end else begin
        query_bus.valid <= 1'b0;
      end
    end
  end

  // answer receiver, with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      answer_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      answer_bus.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 300;
      answer_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      answer_bus.ready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      stall_left = $urandom_range(0, 8);
      answer_bus.ready <= 1'b0;
    end else begin
      answer_bus.ready <= 1'b1;
    end
  end

  // answer checker
  always @(posedge clk) begin
    if (!rst && answer_bus.valid && answer_bus.ready) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected answer status %0d group %0d", $time,
                 answer_bus.status, answer_bus.group_index);
        mismatches++;
      end else begin
        head_answer = expected_answers.pop_front();
        status_seen[int'(head_answer.status)]++;
        if (answer_bus.status !== head_answer.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   head_answer.status, answer_bus.status);
          mismatches++;
        end
        if (answer_bus.group_index !== head_answer.group) begin
          $display("%0t: group_index expected %0d actual %0d", $time,
                   head_answer.group, answer_bus.group_index);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < MAX_BUCKETS_DEF; i++) bkt_used[i] = 1'b0;
    group_count = '0;
    cfg_lg = LG_RESET;
    cfg_max = MAXE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // two buckets: fill both, then probe a full table
    set_config(4'd1, 10'd1023);
    push_query(CMD_FIND_OR_CREATE, 64'd0, 64'd0);
    push_query(CMD_FIND_OR_CREATE, '1, '1);
    push_query(CMD_FIND_OR_CREATE, 64'd0, 64'd0);
    push_query(CMD_FIND_OR_CREATE, 64'd2, 64'd5);
    push_query(CMD_FIND_ONLY, 64'd2, 64'd5);
    push_query(CMD_FIND_OR_CREATE, 64'd0, 64'd1);
    push_query(CMD_FIND_ONLY, '1, '1);
    push_query(CMD_FIND_ONLY, '1, 64'd0);
    // size below range clamps up, no inserts allowed
    set_config(4'd0, 10'd0);
    push_query(CMD_FIND_ONLY, 64'd0, 64'd0);
    push_query(CMD_FIND_OR_CREATE, '1, '1);
    // size above range clamps down; old buckets stay where they were
    set_config(4'd15, 10'd0);
    push_query(CMD_FIND_OR_CREATE, 64'h400, 64'd3);
    push_query(CMD_FIND_ONLY, 64'h401, 64'd3);
    push_query(CMD_FIND_ONLY, '1, '1);
    set_config(4'd11, 10'd3);
    push_query(CMD_FIND_OR_CREATE, 64'h400, 64'd3);
    push_query(CMD_FIND_OR_CREATE, {32{2'b01}}, {32{2'b10}});
    push_query(CMD_FIND_ONLY, 64'h400, 64'd3);
    push_query(CMD_FIND_OR_CREATE, 64'h3ff, '1);

    random_phase(4'd4, 10'd1023, 250, 25);
    hold_req = 1'b1;
    random_phase(4'd10, 10'd400, 500, 10);
    random_phase(4'd8, 10'd1023, 300, 0);
    random_phase(4'd2, 10'd1, 100, 25);
    random_phase(4'd15, 10'd1023, 350, 10);
    wait_idle();
    idle_pct = 0;
    repeat (150) pending_queries = {pending_queries, random_query()};

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Ran %0d queries at 2 to 1024 buckets and load limits 0 to 1023; %0d groups made.",
             answers_seen, group_count);
    $display("Answers: %0d matched, %0d created, %0d not found, %0d full.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("%0t: timeout with %0d answers outstanding", $time, expected_answers.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lpgt_pkg.sv
src/lpgt_if.sv
src/lpgt_ram.sv
src/linear_probe_group_table.sv
src/lpgt_checker.sv
sim/tb_linear_probe_group_table.sv
